>>> rtl/core/bfha_pkg.sv
// Shared constants, types and status codes of the best-fit heap allocator.
// Used by the channel interfaces, the block table and the sequencer.
`timescale 1ns / 1ps
package bfha_pkg;

   localparam int HEAP_BYTES   = 65536;
   localparam int HEADER_BYTES = 20;
   localparam int ALIGN_BYTES  = 4096;
   localparam int MAX_BLOCKS   = 64;

   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int OFF_W   = $clog2(HEAP_BYTES);
   localparam int SIZE_W  = OFF_W;
   localparam int ADDR_W  = 32;
   localparam int REQ_W   = 17;
   localparam int SUM_W   = ADDR_W + 3;
   localparam int ALIGN_W = $clog2(ALIGN_BYTES);

   localparam logic [SUM_W-1:0] HDR_SUM   = SUM_W'(HEADER_BYTES);
   localparam logic [SUM_W-1:0] HEAP_SUM  = SUM_W'(HEAP_BYTES);
   localparam logic [SUM_W-1:0] ALIGN_M1  = SUM_W'(ALIGN_BYTES - 1);
   localparam logic [SUM_W-1:0] ALIGN_MSK = ~ALIGN_M1;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_ZERO     = 3'd1,
      STAT_NOFIT    = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_RANGE    = 3'd4,
      STAT_NOTBLOCK = 3'd5,
      STAT_DOUBLE   = 3'd6
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef struct packed {
      logic [OFF_W-1:0]  off;
      logic [SIZE_W-1:0] size;
      logic              is_free;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } tbl_req_type;

endpackage

>>> rtl/core/bfha_if.sv
// Valid/ready channel interfaces of the allocator: request, response, register write.
// Depends on bfha_pkg for the field widths.
`timescale 1ns / 1ps
interface bfha_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [bfha_pkg::REQ_W-1:0]  req_size;
   logic                        align_req;
   logic [bfha_pkg::ADDR_W-1:0] free_addr;
   modport source (output valid, op, req_size, align_req, free_addr, input ready);
   modport sink   (input valid, op, req_size, align_req, free_addr, output ready);
endinterface

interface bfha_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [2:0]                  status;
   logic [bfha_pkg::ADDR_W-1:0] blk_addr;
   modport source (output valid, status, blk_addr, input ready);
   modport sink   (input valid, status, blk_addr, output ready);
endinterface

interface bfha_csr_if;
   logic                        valid;
   logic                        ready;
   logic [bfha_pkg::ADDR_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/best_fit_heap_allocator_top.sv
// Top level of the best-fit heap allocator with coalescing.
// Depends on bfha_pkg, the channel interfaces, bfha_ctrl and bfha_table.
`timescale 1ns / 1ps
// One request at a time: req_if.ready is high only while the block is idle and
// each request gives exactly one rsp_if beat. An allocation scans every valid entry
// of the block table through the single table read port (read, latency and evaluate
// states per entry), then moves each entry above the chosen block up to open room
// (a read and a write state per entry), and then writes up to three entries; a free
// scans up to its block, then closes the gap by moving the entries above it down.
// The heap_base register is written through csr_if, which is always ready and is
// to be written only while no request is in flight. No clearing pass follows reset.
module best_fit_heap_allocator_top (
   input logic     clock,
   input logic     reset,
   bfha_req_if.sink   req_if,
   bfha_rsp_if.source rsp_if,
   bfha_csr_if.sink   csr_if
);

   bfha_pkg::tbl_req_type tbl_req;
   bfha_pkg::entry_type   rd_data;

   assign csr_if.ready = 1'b1;

   bfha_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_op        (req_if.op),
      .req_size      (req_if.req_size),
      .req_align     (req_if.align_req),
      .req_free_addr (req_if.free_addr),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_status    (rsp_if.status),
      .rsp_blk_addr  (rsp_if.blk_addr),
      .csr_valid     (csr_if.valid),
      .csr_data      (csr_if.data),
      .tbl_req       (tbl_req),
      .rd_data       (rd_data)
   );

   bfha_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_data (rd_data)
   );

endmodule

>>> rtl/core/bfha_table.sv
// Block table memory: one write and one registered read port.
// Entry 0 reads as the whole-heap free block until first written. Depends on bfha_pkg.
`timescale 1ns / 1ps
module bfha_table (
   input  logic                 clock,
   input  logic                 reset,
   input  bfha_pkg::tbl_req_type tbl_req,
   output bfha_pkg::entry_type  rd_data
);

   bfha_pkg::entry_type mem [bfha_pkg::MAX_BLOCKS];
   bfha_pkg::entry_type rd_data_ff;
   bfha_pkg::entry_type init_ent;
   logic                ent0_ff;

   assign init_ent.off     = '0;
   assign init_ent.size    = bfha_pkg::SIZE_W'(bfha_pkg::HEAP_BYTES - bfha_pkg::HEADER_BYTES);
   assign init_ent.is_free = 1'b1;

   always_ff @(posedge clock) begin
      if (tbl_req.we) begin
         mem[tbl_req.waddr] <= tbl_req.wdata;
      end
      if (tbl_req.raddr == '0 && ent0_ff) begin
         rd_data_ff <= init_ent;
      end else begin
         rd_data_ff <= mem[tbl_req.raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent0_ff <= 1'b1;
      end else if (tbl_req.we && tbl_req.waddr == '0) begin
         ent0_ff <= 1'b0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bfha_ctrl.sv
// Sequencer of the allocator: table scan, fit and merge arithmetic, shift and write-back.
// Depends on bfha_pkg; drives the table port of bfha_table.
`timescale 1ns / 1ps
module bfha_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [bfha_pkg::REQ_W-1:0]   req_size,
   input  logic                         req_align,
   input  logic [bfha_pkg::ADDR_W-1:0]  req_free_addr,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_status,
   output logic [bfha_pkg::ADDR_W-1:0]  rsp_blk_addr,
   input  logic                         csr_valid,
   input  logic [bfha_pkg::ADDR_W-1:0]  csr_data,
   output bfha_pkg::tbl_req_type        tbl_req,
   input  bfha_pkg::entry_type          rd_data
);

   localparam int CW = bfha_pkg::CNT_W;
   localparam int SW = bfha_pkg::SUM_W;
   localparam int IW = bfha_pkg::IDX_W;

   typedef enum logic [12:0] {
      S_IDLE       = 13'b0000000000001,
      S_SCAN_RD    = 13'b0000000000010,
      S_SCAN_LAT   = 13'b0000000000100,
      S_SCAN_EVAL  = 13'b0000000001000,
      S_NEXT_RD    = 13'b0000000010000,
      S_NEXT_LAT   = 13'b0000000100000,
      S_FREE_PLAN  = 13'b0000001000000,
      S_ALLOC_PLAN = 13'b0000010000000,
      S_ALLOC_FIN  = 13'b0000100000000,
      S_SHIFT_RD   = 13'b0001000000000,
      S_SHIFT_WR   = 13'b0010000000000,
      S_WRITE      = 13'b0100000000000,
      S_RESP       = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [bfha_pkg::ADDR_W-1:0] base_ff, base_in, fa_ff, fa_in, daddr_ff, daddr_in;
   logic [CW-1:0] count_ff, count_in, i_ff, i_in, best_i_ff, best_i_in;
   logic [CW-1:0] sh_src_ff, sh_src_in, sh_cnt_ff, sh_cnt_in;
   logic [1:0]    sh_amt_ff, sh_amt_in, wr_sel_ff, wr_sel_in;
   logic          sh_up_ff, sh_up_in, op_ff, op_in, al_ff, al_in;
   logic          found_ff, found_in, next_ok_ff, next_ok_in;
   logic [bfha_pkg::REQ_W-1:0] req_ff, req_in;
   bfha_pkg::entry_type cur_ff, cur_in, prev_ff, prev_in, next_ff, next_in;
   bfha_pkg::entry_type best_ff, best_in;
   logic [SW-1:0] d0_ff, d0_in, e_ff, e_in, best_d0_ff, best_d0_in, best_da_ff, best_da_in;
   logic [SW-1:0] pad_ff, pad_in, rem_ff, rem_in;
   logic [2:0]    status_ff, status_in;
   logic          wr_vld_ff [3];
   logic          wr_vld_in [3];
   logic [IW-1:0] wr_addr_ff [3];
   logic [IW-1:0] wr_addr_in [3];
   bfha_pkg::entry_type wr_ent_ff [3];
   bfha_pkg::entry_type wr_ent_in [3];

   logic [SW-1:0] d0_c, e_c, da_c, fa_sum;
   logic          fit_c, range_bad, rem_big, has_pad, pf, nf;
   logic [1:0]    need;
   logic [CW-1:0] used_i, start_i, dst;

   function automatic logic [bfha_pkg::SIZE_W-1:0] SIZE_W_CAST(input logic [SW-1:0] v);
      return v[bfha_pkg::SIZE_W-1:0];
   endfunction

   function automatic logic [bfha_pkg::OFF_W-1:0] OFF_W_CAST(input logic [SW-1:0] v);
      return v[bfha_pkg::OFF_W-1:0];
   endfunction

   assign d0_c   = SW'(base_ff) + SW'(rd_data.off) + bfha_pkg::HDR_SUM;
   assign e_c    = d0_c + SW'(rd_data.size);
   assign da_c   = (al_ff && d0_ff[bfha_pkg::ALIGN_W-1:0] != '0)
                 ? ((d0_ff + bfha_pkg::HDR_SUM + bfha_pkg::ALIGN_M1) & bfha_pkg::ALIGN_MSK)
                 : d0_ff;
   assign fit_c  = (da_c + SW'(req_ff)) <= e_ff;
   assign fa_sum = SW'(fa_ff);
   assign range_bad = (req_free_addr == '0) || (req_free_addr < base_ff)
                    || (SW'(req_free_addr) >= SW'(base_ff) + bfha_pkg::HEAP_SUM);
   assign rem_big = rem_ff > bfha_pkg::HDR_SUM;
   assign has_pad = pad_ff != '0;
   assign need    = {1'b0, has_pad} + {1'b0, rem_big};
   assign used_i  = best_i_ff + CW'(has_pad);
   assign pf      = (i_ff != '0) && prev_ff.is_free;
   assign nf      = next_ok_ff && next_ff.is_free;
   assign start_i = i_ff + (nf ? CW'(2) : CW'(1));
   assign dst     = sh_up_ff ? sh_src_ff + CW'(sh_amt_ff) : sh_src_ff - CW'(sh_amt_ff);

   always_comb begin
      tbl_req.we    = 1'b0;
      tbl_req.waddr = dst[IW-1:0];
      tbl_req.wdata = rd_data;
      tbl_req.raddr = i_ff[IW-1:0];
      case (state_ff)
         S_NEXT_RD:  tbl_req.raddr = IW'(i_ff + CW'(1));
         S_SHIFT_RD: tbl_req.raddr = sh_src_ff[IW-1:0];
         S_SHIFT_WR: tbl_req.we = 1'b1;
         S_WRITE: begin
            tbl_req.we    = wr_vld_ff[wr_sel_ff];
            tbl_req.waddr = wr_addr_ff[wr_sel_ff];
            tbl_req.wdata = wr_ent_ff[wr_sel_ff];
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;   base_in = base_ff;     fa_in = fa_ff;
      daddr_in = daddr_ff;   count_in = count_ff;   i_in = i_ff;
      best_i_in = best_i_ff; sh_src_in = sh_src_ff; sh_cnt_in = sh_cnt_ff;
      sh_amt_in = sh_amt_ff; wr_sel_in = wr_sel_ff; sh_up_in = sh_up_ff;
      op_in = op_ff;         al_in = al_ff;         found_in = found_ff;
      next_ok_in = next_ok_ff; req_in = req_ff;     cur_in = cur_ff;
      prev_in = prev_ff;     next_in = next_ff;     best_in = best_ff;
      d0_in = d0_ff;         e_in = e_ff;           best_d0_in = best_d0_ff;
      best_da_in = best_da_ff; pad_in = pad_ff;     rem_in = rem_ff;
      status_in = status_ff;
      for (int k = 0; k < 3; k++) begin
         wr_vld_in[k]  = wr_vld_ff[k];
         wr_addr_in[k] = wr_addr_ff[k];
         wr_ent_in[k]  = wr_ent_ff[k];
      end
      if (csr_valid) begin
         base_in = csr_data;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_op; req_in = req_size; al_in = req_align; fa_in = req_free_addr;
               daddr_in = '0; i_in = '0; found_in = 1'b0; next_ok_in = 1'b0;
               state_in = S_SCAN_RD;
               if (req_op == bfha_pkg::OP_ALLOC && req_size == '0) begin
                  status_in = bfha_pkg::STAT_ZERO;
                  state_in  = S_RESP;
               end else if (req_op == bfha_pkg::OP_FREE && range_bad) begin
                  status_in = bfha_pkg::STAT_RANGE;
                  state_in  = S_RESP;
               end
            end
         end
         S_SCAN_RD: state_in = S_SCAN_LAT;
         S_SCAN_LAT: begin
            cur_in = rd_data; d0_in = d0_c; e_in = e_c;
            state_in = S_SCAN_EVAL;
         end
         S_SCAN_EVAL: begin
            if (op_ff == bfha_pkg::OP_ALLOC) begin
               if (cur_ff.is_free && fit_c && (!found_ff || cur_ff.size < best_ff.size)) begin
                  found_in = 1'b1; best_i_in = i_ff; best_in = cur_ff;
                  best_d0_in = d0_ff; best_da_in = da_c;
               end
               i_in = i_ff + CW'(1);
               state_in = (i_ff + CW'(1) == count_ff) ? S_ALLOC_PLAN : S_SCAN_RD;
            end else if (d0_ff == fa_sum) begin
               if (cur_ff.is_free) begin
                  status_in = bfha_pkg::STAT_DOUBLE;
                  state_in  = S_RESP;
               end else begin
                  state_in = (i_ff + CW'(1) < count_ff) ? S_NEXT_RD : S_FREE_PLAN;
               end
            end else begin
               prev_in = cur_ff;
               i_in = i_ff + CW'(1);
               if (i_ff + CW'(1) == count_ff) begin
                  status_in = bfha_pkg::STAT_NOTBLOCK;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_NEXT_RD: state_in = S_NEXT_LAT;
         S_NEXT_LAT: begin
            next_in = rd_data; next_ok_in = 1'b1;
            state_in = S_FREE_PLAN;
         end
         S_FREE_PLAN: begin
            wr_vld_in[0] = 1'b1; wr_vld_in[1] = 1'b0; wr_vld_in[2] = 1'b0;
            if (pf) begin
               wr_addr_in[0] = IW'(i_ff - CW'(1));
               wr_ent_in[0].off = prev_ff.off;
               wr_ent_in[0].size = SIZE_W_CAST(SW'(prev_ff.size) + SW'(cur_ff.size)
                  + bfha_pkg::HDR_SUM + (nf ? SW'(next_ff.size) + bfha_pkg::HDR_SUM : '0));
            end else begin
               wr_addr_in[0] = i_ff[IW-1:0];
               wr_ent_in[0].off = cur_ff.off;
               wr_ent_in[0].size = nf ? SIZE_W_CAST(SW'(cur_ff.size) + SW'(next_ff.size)
                  + bfha_pkg::HDR_SUM) : cur_ff.size;
            end
            wr_ent_in[0].is_free = 1'b1;
            sh_up_in  = 1'b0;
            sh_src_in = start_i;
            sh_amt_in = {1'b0, pf} + {1'b0, nf};
            sh_cnt_in = (pf || nf) && start_i < count_ff ? count_ff - start_i : '0;
            count_in  = count_ff - CW'({1'b0, pf} + {1'b0, nf});
            status_in = bfha_pkg::STAT_OK;
            state_in  = S_SHIFT_RD;
         end
         S_ALLOC_PLAN: begin
            if (!found_ff) begin
               status_in = bfha_pkg::STAT_NOFIT;
               state_in  = S_RESP;
            end else begin
               pad_in = best_da_ff - best_d0_ff;
               rem_in = SW'(best_ff.size) - (best_da_ff - best_d0_ff) - SW'(req_ff);
               state_in = S_ALLOC_FIN;
            end
         end
         S_ALLOC_FIN: begin
            if (count_ff + CW'(need) > CW'(bfha_pkg::MAX_BLOCKS)) begin
               status_in = bfha_pkg::STAT_FULL;
               state_in  = S_RESP;
            end else begin
               wr_vld_in[0] = has_pad;
               wr_addr_in[0] = best_i_ff[IW-1:0];
               wr_ent_in[0].off = best_ff.off;
               wr_ent_in[0].size = SIZE_W_CAST(pad_ff - bfha_pkg::HDR_SUM);
               wr_ent_in[0].is_free = 1'b1;
               wr_vld_in[1] = 1'b1;
               wr_addr_in[1] = used_i[IW-1:0];
               wr_ent_in[1].off = OFF_W_CAST(SW'(best_ff.off) + pad_ff);
               wr_ent_in[1].size = rem_big ? SIZE_W_CAST(SW'(req_ff))
                                 : SIZE_W_CAST(SW'(best_ff.size) - pad_ff);
               wr_ent_in[1].is_free = 1'b0;
               wr_vld_in[2] = rem_big;
               wr_addr_in[2] = IW'(used_i + CW'(1));
               wr_ent_in[2].off = OFF_W_CAST(SW'(best_ff.off) + pad_ff
                                 + bfha_pkg::HDR_SUM + SW'(req_ff));
               wr_ent_in[2].size = SIZE_W_CAST(rem_ff - bfha_pkg::HDR_SUM);
               wr_ent_in[2].is_free = 1'b1;
               sh_up_in  = 1'b1;
               sh_src_in = count_ff - CW'(1);
               sh_amt_in = need;
               sh_cnt_in = (need == '0) ? '0 : count_ff - CW'(1) - best_i_ff;
               count_in  = count_ff + CW'(need);
               daddr_in  = best_da_ff[bfha_pkg::ADDR_W-1:0];
               status_in = bfha_pkg::STAT_OK;
               state_in  = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            wr_sel_in = '0;
            state_in = (sh_cnt_ff == '0) ? S_WRITE : S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            sh_src_in = sh_up_ff ? sh_src_ff - CW'(1) : sh_src_ff + CW'(1);
            sh_cnt_in = sh_cnt_ff - CW'(1);
            state_in  = S_SHIFT_RD;
         end
         S_WRITE: begin
            wr_sel_in = wr_sel_ff + 2'd1;
            if (wr_sel_ff == 2'd2) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff  <= '0;
         count_ff <= CW'(1);
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      fa_ff <= fa_in;         daddr_ff <= daddr_in;     i_ff <= i_in;
      best_i_ff <= best_i_in; sh_src_ff <= sh_src_in;   sh_cnt_ff <= sh_cnt_in;
      sh_amt_ff <= sh_amt_in; wr_sel_ff <= wr_sel_in;   sh_up_ff <= sh_up_in;
      op_ff <= op_in;         al_ff <= al_in;           found_ff <= found_in;
      next_ok_ff <= next_ok_in; req_ff <= req_in;       cur_ff <= cur_in;
      prev_ff <= prev_in;     next_ff <= next_in;       best_ff <= best_in;
      d0_ff <= d0_in;         e_ff <= e_in;             best_d0_ff <= best_d0_in;
      best_da_ff <= best_da_in; pad_ff <= pad_in;       rem_ff <= rem_in;
      status_ff <= status_in;
      for (int k = 0; k < 3; k++) begin
         wr_vld_ff[k]  <= wr_vld_in[k];
         wr_addr_ff[k] <= wr_addr_in[k];
         wr_ent_ff[k]  <= wr_ent_in[k];
      end
   end

   assign req_ready     = state_ff == S_IDLE;
   assign rsp_valid     = state_ff == S_RESP;
   assign rsp_status    = status_ff;
   assign rsp_blk_addr  = daddr_ff;

endmodule

>>> tb/sv/best_fit_heap_allocator_top_tb.sv
// Self-checking bench for best_fit_heap_allocator_top: random and directed
// allocate/free beats checked against an in-bench best-fit table predictor.
// Depends on bfha_pkg and the channel interfaces in bfha_if.
`timescale 1ns / 1ps
module best_fit_heap_allocator_top_tb;

   typedef struct {
      bfha_pkg::op_type op;
      logic [16:0]      size;
      logic             align;
      logic [31:0]      addr;
   } heap_req_type;

   typedef struct {
      bfha_pkg::status_type status;
      logic [31:0]          addr;
   } heap_rsp_type;

   typedef struct {
      longint unsigned off;
      longint unsigned size;
      bit              is_free;
   } blk_type;

   logic clock;
   logic reset;
   bfha_req_if req_if();
   bfha_rsp_if rsp_if();
   bfha_csr_if csr_if();

   best_fit_heap_allocator_top DUT (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if), .csr_if(csr_if)
   );

   blk_type         blocks[$];
   longint unsigned base_addr;
   logic [31:0]     live_addrs[$];
   heap_req_type    pending_reqs[$];
   heap_rsp_type    expected_rsps[$];
   int              errors = 0;
   int              cycles = 0;
   int              burst_left;
   int              gap_left;
   bit              drive_en;
   bit              hold_for_drain;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned align_up(longint unsigned x);
      return (x + bfha_pkg::ALIGN_BYTES - 1) / bfha_pkg::ALIGN_BYTES * bfha_pkg::ALIGN_BYTES;
   endfunction

   function automatic heap_rsp_type heap_alloc(longint unsigned req, bit al);
      heap_rsp_type    r;
      int              best;
      bit              found;
      longint unsigned d, e, data, pad, rem;
      int              need;
      blk_type         nb;
      r.status = bfha_pkg::STAT_OK;
      r.addr = 0;
      best = 0;
      found = 0;
      pad = 0;
      if (req == 0) begin
         r.status = bfha_pkg::STAT_ZERO;
         return r;
      end
      for (int i = 0; i < blocks.size(); i++) begin
         if (!blocks[i].is_free) continue;
         d = base_addr + blocks[i].off + bfha_pkg::HEADER_BYTES;
         e = d + blocks[i].size;
         if (al && (d % bfha_pkg::ALIGN_BYTES) != 0) d = align_up(d + bfha_pkg::HEADER_BYTES);
         if (d + req <= e && (!found || blocks[i].size < blocks[best].size)) begin
            best = i;
            found = 1;
         end
      end
      if (!found) begin
         r.status = bfha_pkg::STAT_NOFIT;
         return r;
      end
      data = base_addr + blocks[best].off + bfha_pkg::HEADER_BYTES;
      if (al && (data % bfha_pkg::ALIGN_BYTES) != 0)
         pad = align_up(data + bfha_pkg::HEADER_BYTES) - data;
      if (blocks[best].size < req + pad) begin
         r.status = bfha_pkg::STAT_NOFIT;
         return r;
      end
      rem = blocks[best].size - pad - req;
      need = (pad != 0) + (rem > bfha_pkg::HEADER_BYTES);
      if (blocks.size() + need > bfha_pkg::MAX_BLOCKS) begin
         r.status = bfha_pkg::STAT_FULL;
         return r;
      end
      if (pad != 0) begin
         nb.off = blocks[best].off + pad;
         nb.size = blocks[best].size - pad;
         nb.is_free = 1;
         blocks.insert(best + 1, nb);
         blocks[best].size = pad - bfha_pkg::HEADER_BYTES;
         best++;
      end
      blocks[best].is_free = 0;
      if (rem > bfha_pkg::HEADER_BYTES) begin
         nb.off = blocks[best].off + bfha_pkg::HEADER_BYTES + req;
         nb.size = rem - bfha_pkg::HEADER_BYTES;
         nb.is_free = 1;
         blocks.insert(best + 1, nb);
         blocks[best].size = req;
      end
      r.addr = 32'(base_addr + blocks[best].off + bfha_pkg::HEADER_BYTES);
      return r;
   endfunction

   function automatic bfha_pkg::status_type heap_free(longint unsigned fa);
      int i;
      bit found;
      found = 0;
      if (fa == 0 || fa < base_addr || fa >= base_addr + bfha_pkg::HEAP_BYTES)
         return bfha_pkg::STAT_RANGE;
      for (i = 0; i < blocks.size(); i++) begin
         if (base_addr + blocks[i].off + bfha_pkg::HEADER_BYTES == fa) begin
            found = 1;
            break;
         end
      end
      if (!found) return bfha_pkg::STAT_NOTBLOCK;
      if (blocks[i].is_free) return bfha_pkg::STAT_DOUBLE;
      blocks[i].is_free = 1;
      if (i > 0 && blocks[i-1].is_free) begin
         blocks[i-1].size += blocks[i].size + bfha_pkg::HEADER_BYTES;
         blocks.delete(i);
         i--;
      end
      if (i + 1 < blocks.size() && blocks[i+1].is_free) begin
         blocks[i].size += blocks[i+1].size + bfha_pkg::HEADER_BYTES;
         blocks.delete(i + 1);
      end
      return bfha_pkg::STAT_OK;
   endfunction

   function automatic heap_rsp_type predict_heap(heap_req_type q);
      heap_rsp_type r;
      if (q.op == bfha_pkg::OP_ALLOC) begin
         r = heap_alloc(q.size, q.align);
      end else begin
         r.status = heap_free(q.addr);
         r.addr = 0;
      end
      if (r.status != bfha_pkg::STAT_OK) r.addr = 0;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_rsps.push_back(predict_heap(pending_reqs.pop_front()));
         end
         if (req_if.valid && !req_if.ready) begin
            // hold
         end else if (gap_left > 0) begin
            req_if.valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (drive_en && !hold_for_drain && pending_reqs.size() > 0) begin
            req_if.valid     <= 1'b1;
            req_if.op        <= pending_reqs[0].op;
            req_if.req_size  <= pending_reqs[0].size;
            req_if.align_req <= pending_reqs[0].align;
            req_if.free_addr <= pending_reqs[0].addr;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 150);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor and response stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected beat: status=%0d blk_addr=%h", rsp_if.status,
                      rsp_if.blk_addr);
               errors++;
            end else begin
               if (rsp_if.status !== expected_rsps[0].status) begin
                  $error("status: expected %0d actual %0d", expected_rsps[0].status,
                         rsp_if.status);
                  errors++;
               end
               if (rsp_if.blk_addr !== expected_rsps[0].addr) begin
                  $error("blk_addr: expected %h actual %h", expected_rsps[0].addr,
                         rsp_if.blk_addr);
                  errors++;
               end
               if (rsp_if.status == bfha_pkg::STAT_OK && expected_rsps[0].addr != 0)
                  live_addrs.push_back(expected_rsps[0].addr);
               void'(expected_rsps.pop_front());
            end
         end
         if ((cycles / 2000) % 3 == 0) rsp_if.ready <= 1'b1;
         else rsp_if.ready <= ((cycles % 37) < 25) || ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 6000000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic heap_req_type mk_alloc(int unsigned sz, bit al);
      heap_req_type q;
      q.op = bfha_pkg::OP_ALLOC;
      q.size = 17'(sz);
      q.align = al;
      q.addr = $urandom;
      return q;
   endfunction

   function automatic heap_req_type mk_free(logic [31:0] a);
      heap_req_type q;
      q.op = bfha_pkg::OP_FREE;
      q.size = 17'($urandom);
      q.align = $urandom_range(0, 1);
      q.addr = a;
      return q;
   endfunction

   task automatic wait_drain();
      while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_base(logic [31:0] b);
      csr_if.valid <= 1'b1;
      csr_if.data <= b;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      base_addr = b;
   endtask

   task automatic run_random(int n);
      int k;
      logic [31:0] a;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 40) begin
            pending_reqs.push_back(mk_alloc(($urandom_range(0, 9) == 0) ?
                                   $urandom_range(0, 131071) : $urandom_range(1, 2000),
                                   $urandom_range(0, 3) == 0));
         end else if (k < 80 && live_addrs.size() > 0) begin
            k = $urandom_range(0, live_addrs.size() - 1);
            a = live_addrs[k];
            live_addrs.delete(k);
            pending_reqs.push_back(mk_free(a));
         end else if (k < 85) begin
            pending_reqs.push_back(mk_free(32'(base_addr + $urandom_range(0, 65600))));
         end else if (k < 90) begin
            pending_reqs.push_back(mk_free($urandom));
         end else begin
            pending_reqs.push_back(mk_alloc($urandom_range(1, 300), $urandom_range(0, 1)));
         end
         if (pending_reqs.size() > 8) begin
            while (pending_reqs.size() > 2) @(posedge clock);
         end
      end
      while (pending_reqs.size() > 0) @(posedge clock);
   endtask

   initial begin
      blk_type b0;
      drive_en = 0;
      hold_for_drain = 0;
      base_addr = 0;
      b0.off = 0;
      b0.size = bfha_pkg::HEAP_BYTES - bfha_pkg::HEADER_BYTES;
      b0.is_free = 1;
      blocks.push_back(b0);
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.op = bfha_pkg::OP_ALLOC;
      req_if.req_size = '0;
      req_if.align_req = 1'b0;
      req_if.free_addr = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      drive_en = 1;

      // directed
      pending_reqs.push_back(mk_alloc(0, 0));
      pending_reqs.push_back(mk_alloc(65536, 0));
      pending_reqs.push_back(mk_alloc(131071, 1));
      pending_reqs.push_back(mk_alloc(100, 1));
      pending_reqs.push_back(mk_alloc(1, 0));
      pending_reqs.push_back(mk_alloc(30, 0));
      pending_reqs.push_back(mk_free(32'd0));
      pending_reqs.push_back(mk_free(32'hFFFF_FFFF));
      pending_reqs.push_back(mk_free(32'd65536));
      pending_reqs.push_back(mk_free(32'd21));
      pending_reqs.push_back(mk_free(32'd4096));
      pending_reqs.push_back(mk_free(32'd4096));
      pending_reqs.push_back(mk_free(32'd20));
      wait_drain();
      live_addrs.delete();
      for (int i = 0; i < 70; i++) pending_reqs.push_back(mk_alloc(8, 0));
      wait_drain();

      write_base(32'hFFFF_F000);
      run_random(300);
      wait_drain();
      hold_for_drain = 1;
      repeat (10) @(posedge clock);
      hold_for_drain = 0;
      write_base(32'h0001_0000);
      run_random(500);
      wait_drain();
      write_base(32'h0000_0000);
      run_random(500);
      wait_drain();
      write_base({$urandom_range(0, 1048575), 12'h000});
      run_random(500);
      wait_drain();

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
